@@ design/dlsch_pkg.sv @@
package dlsch_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_NIGHT_HOURS = 2'd2;

	// field widths
	localparam int LEVEL_W = 10;
	localparam int LONG_W  = 8;
	localparam int HOUR_W  = 5;
	localparam int PORT_W  = 4;

	// register reset values
	localparam logic [LEVEL_W-1:0] LOWER_LIMIT_RST      = 10'd400;
	localparam logic [LEVEL_W-1:0] UPPER_LIMIT_RST      = 10'd520;
	localparam logic [LONG_W-1:0]  LONG_NIGHT_HOURS_RST = 8'd8;

	// default saturation point of the night counter
	localparam int NIGHT_COUNT_MAX_DEF = 255;

	// last valid hour of the day
	localparam int HOUR_MAX = 23;

	// blackout windows, inclusive
	localparam logic [HOUR_W-1:0] BLK_DST_LO = 5'd2;
	localparam logic [HOUR_W-1:0] BLK_DST_HI = 5'd6;
	localparam logic [HOUR_W-1:0] BLK_STD_LO = 5'd1;
	localparam logic [HOUR_W-1:0] BLK_STD_HI = 5'd5;

	typedef struct packed {
		logic [LEVEL_W-1:0] lower_limit;
		logic [LEVEL_W-1:0] upper_limit;
		logic [LONG_W-1:0]  long_night_hours;
	} cfg_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic              lamp_on;
		logic              is_night;
		logic              dst_active;
		logic [PORT_W-1:0] port_c_bits;
		logic [PORT_W-1:0] port_d_bits;
	} result_t;

endpackage

@@ design/dlsch_cfg.sv @@
module dlsch_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dlsch_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dlsch_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	output dlsch_pkg::cfg_t                   cfg
);

	dlsch_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_limit      <= dlsch_pkg::LOWER_LIMIT_RST;
			cfg_q.upper_limit      <= dlsch_pkg::UPPER_LIMIT_RST;
			cfg_q.long_night_hours <= dlsch_pkg::LONG_NIGHT_HOURS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dlsch_pkg::REG_LOWER_LIMIT: begin
					cfg_q.lower_limit <= cfg_wr_data[dlsch_pkg::LEVEL_W-1:0];
				end
				dlsch_pkg::REG_UPPER_LIMIT: begin
					cfg_q.upper_limit <= cfg_wr_data[dlsch_pkg::LEVEL_W-1:0];
				end
				dlsch_pkg::REG_LONG_NIGHT_HOURS: begin
					cfg_q.long_night_hours <= cfg_wr_data[dlsch_pkg::LONG_W-1:0];
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/dlsch_step.sv @@
module dlsch_step #(
	parameter int NIGHT_COUNT_MAX = dlsch_pkg::NIGHT_COUNT_MAX_DEF,
	parameter int NIGHT_W         = $clog2(NIGHT_COUNT_MAX + 1)
) (
	input  logic                              command,
	input  logic [dlsch_pkg::LEVEL_W-1:0]     raw_sample,
	input  dlsch_pkg::cfg_t                   cfg,
	input  logic [dlsch_pkg::HOUR_W-1:0]      hour_cur,
	input  logic [NIGHT_W-1:0]                night_len_cur,
	input  logic                              night_cur,
	input  logic                              dst_cur,
	output logic [dlsch_pkg::HOUR_W-1:0]      hour_nxt,
	output logic [NIGHT_W-1:0]                night_len_nxt,
	output logic                              night_nxt,
	output logic                              dst_nxt,
	output dlsch_pkg::result_t                result
);

	// wide enough for half the night length plus the correction hour
	localparam int HW = NIGHT_W + 1;
	// common width for the long-night compare
	localparam int CW = (NIGHT_W > dlsch_pkg::LONG_W) ? NIGHT_W : dlsch_pkg::LONG_W;

	logic [dlsch_pkg::LEVEL_W-1:0] level;
	logic [HW-1:0]                 h_w;
	logic                          blackout;

	// 1023 - raw is the bitwise inverse at ten bits
	assign level = ~raw_sample;

	always_comb begin
		h_w           = HW'(hour_cur);
		night_len_nxt = night_len_cur;
		night_nxt     = night_cur;
		dst_nxt       = dst_cur;
		if (command) begin
			h_w = HW'(hour_cur) + HW'(1);
			if (night_len_cur < NIGHT_W'(NIGHT_COUNT_MAX)) begin
				night_len_nxt = night_len_cur + NIGHT_W'(1);
			end
		end else begin
			if ((level < cfg.lower_limit) && !night_cur) begin
				night_nxt     = 1'b1;
				night_len_nxt = '0;
			end else if ((level > cfg.upper_limit) && night_cur) begin
				night_nxt = 1'b0;
				if (CW'(night_len_cur) > CW'(cfg.long_night_hours)) begin
					dst_nxt = 1'b1;
					h_w     = HW'(night_len_cur >> 1) + HW'(1);
				end else begin
					dst_nxt = 1'b0;
					h_w     = HW'(night_len_cur >> 1);
				end
			end
		end
		// wrap past the end of the day
		if (h_w > HW'(dlsch_pkg::HOUR_MAX)) begin
			hour_nxt = '0;
		end else begin
			hour_nxt = h_w[dlsch_pkg::HOUR_W-1:0];
		end
	end

	always_comb begin
		if (dst_nxt) begin
			blackout = (hour_nxt >= dlsch_pkg::BLK_DST_LO) && (hour_nxt <= dlsch_pkg::BLK_DST_HI);
		end else begin
			blackout = (hour_nxt >= dlsch_pkg::BLK_STD_LO) && (hour_nxt <= dlsch_pkg::BLK_STD_HI);
		end
	end

	always_comb begin
		result.hour        = hour_nxt;
		result.lamp_on     = night_nxt && !blackout;
		result.is_night    = night_nxt;
		result.dst_active  = dst_nxt;
		// display pins are port_c {0, hour[4:2]} and port_d {lamp, 0, hour[1:0]}
		result.port_c_bits = {1'b0, hour_nxt[4:2]};
		result.port_d_bits = {result.lamp_on, 1'b0, hour_nxt[1:0]};
	end

endmodule

@@ design/dusk_dawn_lamp_scheduler_top.sv @@
// dusk/dawn street lamp scheduler
//
// input channel: in_valid / in_stall with command (0 = light sample,
// 1 = hour tick) and raw_sample; a word is taken when in_valid is high
// and in_stall is low
// output channel: out_valid / out_stall with hour, lamp_on, is_night,
// dst_active and the display pin groups port_c_bits and port_d_bits;
// exactly one result word per input word, in order
// config: cfg_wr_en / cfg_index / cfg_wr_data write the lower limit,
// upper limit and long-night length; write only while the block is idle
//
// latency: a word taken at one edge lands in the input register there and
// shows on the output right after the next edge (then in the result register)
// throughput: one word per cycle; the clock estimate, night counter and
// flags update in the single step between the two registers
// stall: a stalled result holds in the result register while one more word
// waits in the input register; in_stall rises only when both are full
// reset: clock estimate, night counter, night and dst flags clear to zero,
// limits return to 400 / 520 / 8, both stages empty
module dusk_dawn_lamp_scheduler_top #(
	parameter int NIGHT_COUNT_MAX = dlsch_pkg::NIGHT_COUNT_MAX_DEF,
	parameter int NIGHT_W         = $clog2(NIGHT_COUNT_MAX + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [dlsch_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dlsch_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [dlsch_pkg::LEVEL_W-1:0]     raw_sample,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [dlsch_pkg::HOUR_W-1:0]      hour,
	output logic                              lamp_on,
	output logic                              is_night,
	output logic                              dst_active,
	output logic [dlsch_pkg::PORT_W-1:0]      port_c_bits,
	output logic [dlsch_pkg::PORT_W-1:0]      port_d_bits
);

	dlsch_pkg::cfg_t cfg;

	// input register
	logic                          valid_s1;
	logic                          command_s1;
	logic [dlsch_pkg::LEVEL_W-1:0] raw_s1;

	// result register
	logic                          valid_s2;
	dlsch_pkg::result_t            result_s2;

	// scheduler state
	logic [dlsch_pkg::HOUR_W-1:0]  hour_q;
	logic [NIGHT_W-1:0]            night_len_q;
	logic                          night_q;
	logic                          dst_q;

	// next state from the step logic
	logic [dlsch_pkg::HOUR_W-1:0]  hour_nxt;
	logic [NIGHT_W-1:0]            night_len_nxt;
	logic                          night_nxt;
	logic                          dst_nxt;
	dlsch_pkg::result_t            result_nxt;

	logic                          advance;

	dlsch_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	dlsch_step #(
		.NIGHT_COUNT_MAX (NIGHT_COUNT_MAX),
		.NIGHT_W         (NIGHT_W)
	) u_step (
		.command       (command_s1),
		.raw_sample    (raw_s1),
		.cfg           (cfg),
		.hour_cur      (hour_q),
		.night_len_cur (night_len_q),
		.night_cur     (night_q),
		.dst_cur       (dst_q),
		.hour_nxt      (hour_nxt),
		.night_len_nxt (night_len_nxt),
		.night_nxt     (night_nxt),
		.dst_nxt       (dst_nxt),
		.result        (result_nxt)
	);

	// the result register moves when empty or when its word is taken
	assign advance  = !valid_s2 || !out_stall;
	// hold off the sender only when both stages are occupied
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			raw_s1     <= raw_sample;
		end
	end

	// state commits when the word enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			hour_q      <= '0;
			night_len_q <= '0;
			night_q     <= 1'b0;
			dst_q       <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				hour_q      <= hour_nxt;
				night_len_q <= night_len_nxt;
				night_q     <= night_nxt;
				dst_q       <= dst_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign hour        = result_s2.hour;
	assign lamp_on     = result_s2.lamp_on;
	assign is_night    = result_s2.is_night;
	assign dst_active  = result_s2.dst_active;
	assign port_c_bits = result_s2.port_c_bits;
	assign port_d_bits = result_s2.port_d_bits;

	// the shown word always matches the committed state
	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.hour == hour_q && result_s2.is_night == night_q
			&& result_s2.dst_active == dst_q))
		else $error("result word out of step with scheduler state");

	a_hour_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour_q <= dlsch_pkg::HOUR_W'(dlsch_pkg::HOUR_MAX))
		else $error("hour estimate past end of day");

	a_night_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		night_len_q <= NIGHT_W'(NIGHT_COUNT_MAX))
		else $error("night counter past its limit");

	a_lamp_needs_night: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (!result_s2.lamp_on || result_s2.is_night))
		else $error("lamp lit outside night");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule
